// ===== rtl/bip_pkg.sv =====
// Shared types and constants for the beacon information-element summary parser.
// Holds the queue record passed from the byte walker to the result formatter.
// No dependencies.
package bip_pkg;

  // Element identifiers that the walker keeps.
  localparam logic [7:0] ID_SSID     = 8'h00;
  localparam logic [7:0] ID_RATES    = 8'h01;
  localparam logic [7:0] ID_EXT_RATE = 8'h32;
  localparam logic [7:0] ID_VHT_OP   = 8'hC0;
  localparam logic [7:0] ID_HT_OP    = 8'h3D;

  // Found-flag bits, one per wanted element kind.
  localparam int unsigned FLAG_RATES = 0;
  localparam int unsigned FLAG_EXT   = 1;
  localparam int unsigned FLAG_VHT   = 2;
  localparam int unsigned FLAG_HT    = 3;

  localparam logic [7:0] RATE_ENTRIES   = 8'd8;
  localparam logic [7:0] BASIC_LIMIT    = 8'h80;
  localparam logic [7:0] SSID_MAX       = 8'd32;
  localparam logic [7:0] BAND_5G_FIRST  = 8'd15;

  // Status codes of the summary.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SSID   = 2'd1;
  localparam logic [1:0] ST_NO_RATES  = 2'd2;
  localparam logic [1:0] ST_BAD_RATES = 2'd3;

  // Channel width codes.
  localparam logic [1:0] CW_20 = 2'd0;
  localparam logic [1:0] CW_40 = 2'd1;
  localparam logic [1:0] CW_80 = 2'd2;

  localparam logic KIND_RATE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Depth of the queue between walker and formatter.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

  // One queue entry: an optional rate and an optional end-of-frame summary.
  typedef struct packed {
    logic       has_rate;
    logic [7:0] rate;
    logic       has_summary;
    logic       first_ssid;
    logic [5:0] ssid_size;
    logic [3:0] found;
    logic       rates_ok;
    logic [3:0] basic_cnt;
    logic [3:0] plain_cnt;
    logic [3:0] ext_cnt;
    logic       vht_wide;
    logic       ht_40;
    logic [7:0] chan;
  } bip_rec_t;

  function automatic logic [3:0] kind_flag(input logic [7:0] id);
    logic [3:0] f;
    f = 4'b0000;
    if (id == ID_RATES)    f[FLAG_RATES] = 1'b1;
    if (id == ID_EXT_RATE) f[FLAG_EXT]   = 1'b1;
    if (id == ID_VHT_OP)   f[FLAG_VHT]   = 1'b1;
    if (id == ID_HT_OP)    f[FLAG_HT]    = 1'b1;
    return f;
  endfunction

endpackage

// ===== rtl/bip_front.sv =====
// Byte walker: follows the element chain one byte per item and queues records.
// Depends on bip_pkg.
module bip_front #(
  parameter int unsigned MAX_AREA_BYTES     = 2048,
  parameter int unsigned MAX_EXTENDED_RATES = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       ie_byte,
  input  logic [11:0]      area_length,
  input  logic [7:0]       rx_channel,
  input  logic             end_of_frame,
  output logic             rec_push,
  output bip_pkg::bip_rec_t rec
);
  import bip_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_AREA_BYTES + 1);
  localparam int unsigned EXT_W = $clog2(MAX_EXTENDED_RATES + 1);
  localparam int unsigned AW    = ((POS_W > 12) ? POS_W : 12) + 2;

  localparam logic [1:0] PH_ID   = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [POS_W-1:0] pos, pos_next;
  logic [1:0]       phase, phase_next;
  logic [7:0]       kind, kind_next;
  logic [7:0]       remaining, remaining_next;
  logic [7:0]       index, index_next;
  logic [3:0]       found, found_next;
  logic             first_ssid, first_ssid_next;
  logic [5:0]       ssid_size, ssid_size_next;
  logic [7:0]       rates_len, rates_len_next;
  logic [3:0]       basic_cnt, basic_cnt_next;
  logic [3:0]       plain_cnt, plain_cnt_next;
  logic [EXT_W-1:0] ext_cnt, ext_cnt_next;
  logic             vht_wide, vht_wide_next;
  logic             ht_40, ht_40_next;
  logic             capturing, capturing_next;

  logic [AW-1:0] alen_raw, alen, pos_ext, pos_m1, avail, b_ext;
  logic [3:0]    fl;
  logic          emit_rate;

  always_comb begin
    pos_next        = pos;
    phase_next      = phase;
    kind_next       = kind;
    remaining_next  = remaining;
    index_next      = index;
    found_next      = found;
    first_ssid_next = first_ssid;
    ssid_size_next  = ssid_size;
    rates_len_next  = rates_len;
    basic_cnt_next  = basic_cnt;
    plain_cnt_next  = plain_cnt;
    ext_cnt_next    = ext_cnt;
    vht_wide_next   = vht_wide;
    ht_40_next      = ht_40;
    capturing_next  = capturing;
    emit_rate       = 1'b0;

    alen_raw = AW'(area_length);
    alen     = (alen_raw > AW'(MAX_AREA_BYTES)) ? AW'(MAX_AREA_BYTES) : alen_raw;
    pos_ext  = AW'(pos);
    pos_m1   = pos_ext - AW'(1);
    avail    = (pos_m1 < alen) ? (alen - pos_m1) : '0;
    b_ext    = AW'(ie_byte);
    fl       = kind_flag(kind);

    if (pos == '0) first_ssid_next = (ie_byte == ID_SSID);
    if (pos == POS_W'(1)) begin
      ssid_size_next = (ie_byte > SSID_MAX) ? SSID_MAX[5:0] : ie_byte[5:0];
    end

    unique case (phase)
      PH_ID: begin
        if (pos_ext + AW'(2) > alen) begin
          phase_next = PH_DONE;
        end else begin
          kind_next  = ie_byte;
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b_ext + AW'(2) > avail) begin
          phase_next = PH_DONE;
        end else begin
          capturing_next = 1'b0;
          if (avail >= AW'(3) && fl != 4'b0000 && (found & fl) == 4'b0000) begin
            found_next     = found | fl;
            capturing_next = 1'b1;
            if (fl[FLAG_RATES]) rates_len_next = ie_byte;
            if (fl[FLAG_EXT]) begin
              ext_cnt_next = (ie_byte > 8'(MAX_EXTENDED_RATES)) ?
                             EXT_W'(MAX_EXTENDED_RATES) : EXT_W'(ie_byte);
            end
            if (fl[FLAG_VHT]) vht_wide_next = 1'b0;
            if (fl[FLAG_HT])  ht_40_next    = 1'b0;
          end
          if (ie_byte == 8'd0) begin
            phase_next     = PH_ID;
            capturing_next = 1'b0;
          end else begin
            phase_next     = PH_BODY;
            remaining_next = ie_byte;
            index_next     = 8'd0;
          end
        end
      end
      PH_BODY: begin
        if (capturing) begin
          if (kind == ID_RATES && first_ssid && rates_len == RATE_ENTRIES &&
              index < RATE_ENTRIES) begin
            emit_rate = 1'b1;
            if (ie_byte > BASIC_LIMIT) basic_cnt_next = basic_cnt + 4'd1;
            else                       plain_cnt_next = plain_cnt + 4'd1;
          end
          if (kind == ID_VHT_OP && index == 8'd0) vht_wide_next = (ie_byte != 8'd0);
          if (kind == ID_HT_OP && index == 8'd1)  ht_40_next    = ie_byte[2];
        end
        if (index != 8'hFF) index_next = index + 8'd1;
        remaining_next = remaining - 8'd1;
        if (remaining_next == 8'd0) begin
          phase_next     = PH_ID;
          capturing_next = 1'b0;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    if (pos != POS_W'(MAX_AREA_BYTES)) pos_next = pos + POS_W'(1);
  end

  always_comb begin
    rec.has_rate    = emit_rate;
    rec.rate        = ie_byte;
    rec.has_summary = end_of_frame;
    rec.first_ssid  = first_ssid_next;
    rec.ssid_size   = ssid_size_next;
    rec.found       = found_next;
    rec.rates_ok    = (rates_len_next == RATE_ENTRIES);
    rec.basic_cnt   = basic_cnt_next;
    rec.plain_cnt   = plain_cnt_next;
    rec.ext_cnt     = 4'(ext_cnt_next);
    rec.vht_wide    = vht_wide_next;
    rec.ht_40       = ht_40_next;
    rec.chan        = rx_channel;
  end

  assign rec_push = accept && (emit_rate || end_of_frame);

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_frame)) begin
      pos        <= '0;
      phase      <= PH_ID;
      kind       <= '0;
      remaining  <= '0;
      index      <= '0;
      found      <= '0;
      first_ssid <= 1'b0;
      ssid_size  <= '0;
      rates_len  <= '0;
      basic_cnt  <= '0;
      plain_cnt  <= '0;
      ext_cnt    <= '0;
      vht_wide   <= 1'b0;
      ht_40      <= 1'b0;
      capturing  <= 1'b0;
    end else if (accept) begin
      pos        <= pos_next;
      phase      <= phase_next;
      kind       <= kind_next;
      remaining  <= remaining_next;
      index      <= index_next;
      found      <= found_next;
      first_ssid <= first_ssid_next;
      ssid_size  <= ssid_size_next;
      rates_len  <= rates_len_next;
      basic_cnt  <= basic_cnt_next;
      plain_cnt  <= plain_cnt_next;
      ext_cnt    <= ext_cnt_next;
      vht_wide   <= vht_wide_next;
      ht_40      <= ht_40_next;
      capturing  <= capturing_next;
    end
  end

endmodule

// ===== rtl/bip_queue.sv =====
// Short record queue between the byte walker and the result formatter.
// Depends on bip_pkg.
module bip_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bip_pkg::bip_rec_t wr_rec,
  input  logic              pop,
  output bip_pkg::bip_rec_t rd_rec,
  output logic              full,
  output logic              empty
);
  import bip_pkg::*;

  bip_rec_t             slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_AW:0]    count;

  assign full   = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign rd_rec = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + QUEUE_AW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (QUEUE_AW + 1)'(1);
        2'b01:   count <= count - (QUEUE_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/bip_back.sv =====
// Result formatter: expands queued records into rate and summary results.
// Holds the output register. Depends on bip_pkg.
module bip_back (
  input  logic              clk,
  input  logic              rst,
  input  bip_pkg::bip_rec_t head,
  input  logic              head_valid,
  output logic              head_pop,
  input  logic              pop,
  output logic              empty,
  output logic              kind,
  output logic [7:0]        rate_value,
  output logic              rate_is_basic,
  output logic [8:0]        rate_speed,
  output logic [1:0]        status,
  output logic [5:0]        ssid_length,
  output logic [3:0]        basic_rate_count,
  output logic [3:0]        rate_count,
  output logic              band_5ghz,
  output logic [1:0]        channel_width,
  output logic [1:0]        ht_vht_flags,
  output logic              last_result
);
  import bip_pkg::*;

  logic out_valid;
  logic rate_done;     // rate half of the head record already sent
  logic load;
  logic send_rate;

  logic [4:0] half;
  logic [1:0] st;
  logic [4:0] rc_sum;
  logic       vht;
  logic [1:0] cw;
  logic [1:0] fl;

  assign empty     = !out_valid;
  assign load      = head_valid && (!out_valid || pop);
  assign send_rate = head.has_rate && !rate_done;
  assign head_pop  = load && !(send_rate && head.has_summary);

  always_comb begin
    half   = head.rate[5:1];
    if (!head.first_ssid)               st = ST_NO_SSID;
    else if (!head.found[FLAG_RATES])   st = ST_NO_RATES;
    else if (head.rates_ok)             st = ST_OK;
    else                                st = ST_BAD_RATES;
    rc_sum = 5'(head.plain_cnt) + (head.found[FLAG_EXT] ? 5'(head.ext_cnt) : 5'd0);
    vht    = head.found[FLAG_VHT] && (head.chan > BAND_5G_FIRST);
    fl     = {vht, head.found[FLAG_HT]};
    if (vht)                 cw = head.vht_wide ? CW_80 : CW_40;
    else if (head.found[FLAG_HT]) cw = head.ht_40 ? CW_40 : CW_20;
    else                     cw = CW_20;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rate_done <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        rate_done <= send_rate && head.has_summary;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (send_rate) begin
        kind             <= KIND_RATE;
        rate_value       <= head.rate;
        rate_is_basic    <= (head.rate > BASIC_LIMIT);
        rate_speed       <= {1'b0, half, 3'b000} + {3'b000, half, 1'b0};
        status           <= ST_OK;
        ssid_length      <= '0;
        basic_rate_count <= '0;
        rate_count       <= '0;
        band_5ghz        <= 1'b0;
        channel_width    <= CW_20;
        ht_vht_flags     <= '0;
        last_result      <= 1'b0;
      end else begin
        kind             <= KIND_SUMMARY;
        rate_value       <= '0;
        rate_is_basic    <= 1'b0;
        rate_speed       <= '0;
        status           <= st;
        ssid_length      <= (st == ST_NO_SSID) ? 6'd0 : head.ssid_size;
        basic_rate_count <= (st == ST_OK) ? head.basic_cnt : 4'd0;
        rate_count       <= (st != ST_OK) ? 4'd0 :
                            (rc_sum > 5'd15) ? 4'd15 : rc_sum[3:0];
        band_5ghz        <= (st == ST_OK || st == ST_BAD_RATES) &&
                            (head.chan >= BAND_5G_FIRST);
        channel_width    <= (st == ST_OK || st == ST_BAD_RATES) ? cw : CW_20;
        ht_vht_flags     <= (st == ST_OK || st == ST_BAD_RATES) ? fl : 2'd0;
        last_result      <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/beacon_ie_summary_parser.sv =====
// Beacon / probe-response information-element summary parser, top level.
// A result passes through the record queue and then the output register on its way out.
// The walker takes one item per cycle while the queue is not full, and the formatter loads
// one result per cycle while the output is empty or popped; a byte yielding a rate and the summary gives two results.
// Reset: synchronous, active high; clears the walker, the queue and the output valid flag.
// Depends on bip_pkg, bip_front, bip_queue and bip_back.
module beacon_ie_summary_parser #(
  parameter int unsigned MAX_AREA_BYTES     = 2048,
  parameter int unsigned MAX_EXTENDED_RATES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ie_byte,
  input  logic [11:0] area_length,
  input  logic [7:0]  rx_channel,
  input  logic        end_of_frame,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [7:0]  rate_value,
  output logic        rate_is_basic,
  output logic [8:0]  rate_speed,
  output logic [1:0]  status,
  output logic [5:0]  ssid_length,
  output logic [3:0]  basic_rate_count,
  output logic [3:0]  rate_count,
  output logic        band_5ghz,
  output logic [1:0]  channel_width,
  output logic [1:0]  ht_vht_flags,
  output logic        last_result
);
  import bip_pkg::*;

  // The walker takes one byte every cycle while the record queue has room.
  // Only bytes that give a rate or close the frame leave a record behind;
  // all other bytes just advance the element walk. The formatter drains
  // the queue into the output register, splitting a record that carries
  // both a rate and the summary into two results, rate first.

  logic     accept;
  logic     rec_push;
  bip_rec_t rec_in;
  bip_rec_t rec_head;
  logic     q_empty;
  logic     q_pop;

  assign accept = push && !full;

  bip_front #(
    .MAX_AREA_BYTES     (MAX_AREA_BYTES),
    .MAX_EXTENDED_RATES (MAX_EXTENDED_RATES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .ie_byte      (ie_byte),
    .area_length  (area_length),
    .rx_channel   (rx_channel),
    .end_of_frame (end_of_frame),
    .rec_push     (rec_push),
    .rec          (rec_in)
  );

  // The queue is full only when every slot holds a record; the walker
  // then stalls the input side until the formatter frees a slot.
  bip_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (rec_push),
    .wr_rec (rec_in),
    .pop    (q_pop),
    .rd_rec (rec_head),
    .full   (full),
    .empty  (q_empty)
  );

  bip_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (rec_head),
    .head_valid       (!q_empty),
    .head_pop         (q_pop),
    .pop              (pop),
    .empty            (empty),
    .kind             (kind),
    .rate_value       (rate_value),
    .rate_is_basic    (rate_is_basic),
    .rate_speed       (rate_speed),
    .status           (status),
    .ssid_length      (ssid_length),
    .basic_rate_count (basic_rate_count),
    .rate_count       (rate_count),
    .band_5ghz        (band_5ghz),
    .channel_width    (channel_width),
    .ht_vht_flags     (ht_vht_flags),
    .last_result      (last_result)
  );

endmodule
